// ----- design/adc_decimate_dc_remove_core_assert.svh -----
// assertion macros for the adc decimator and dc removal block
// expects signals named clk and arst_n in the including module
`ifndef ADC_DECIMATE_DC_REMOVE_CORE_ASSERT_SVH
`define ADC_DECIMATE_DC_REMOVE_CORE_ASSERT_SVH

// same-cycle implication
`define ADC_DCR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ADC_DCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/adc_dcr_pkg.sv -----
// shared types and constants for the adc decimator and dc removal block
// no dependencies
package adc_dcr_pkg;

	localparam int RAW_W      = 12;
	localparam int LVL_W      = 8;
	localparam int OFF_W      = 12;
	localparam int WLEN_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam int INV_MAX   = 4095;
	localparam int SCALE_MUL = 255;
	localparam int SCALE_DIV = 1564;
	localparam int SAT_MAX   = 127;
	localparam int SAT_MIN   = -128;
	localparam int PROD_W    = $clog2(INV_MAX * SCALE_MUL + 1);

	localparam int OFF_RESET  = 717;
	localparam int WLEN_RESET = 22;

	localparam int OVERSAMPLE_DEF   = 4;
	localparam int WINDOW_DEPTH_DEF = 64;

	localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(1);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- design/adc_dcr_if.sv -----
// beat channels of the adc decimator: samples in, results out, register writes
// depends on adc_dcr_pkg
interface adc_dcr_in_if;
	logic                                valid;
	logic                                ready;
	logic [adc_dcr_pkg::RAW_W-1:0]       raw_sample;
	logic                                burst_start;
	modport source(output valid, raw_sample, burst_start, input ready);
	modport sink(input valid, raw_sample, burst_start, output ready);
endinterface

interface adc_dcr_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [adc_dcr_pkg::LVL_W-1:0] level_sample;
	logic signed [adc_dcr_pkg::LVL_W-1:0] filtered_sample;
	modport source(output valid, level_sample, filtered_sample, input ready);
	modport sink(input valid, level_sample, filtered_sample, output ready);
endinterface

interface adc_dcr_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [adc_dcr_pkg::CFG_IDX_W-1:0]   index;
	logic [adc_dcr_pkg::CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- design/adc_dcr_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on adc_dcr_pkg
module adc_dcr_div #(
	parameter int W = adc_dcr_pkg::PROD_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [W-1:0]           num,
	input  logic [W-1:0]           den,
	output logic [W-1:0]           quo,
	output adc_dcr_pkg::div_stat_t stat
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic          qbit;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign qbit    = !diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], qbit};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- design/adc_decimate_dc_remove_core.sv -----
// Decimating averager with moving-mean dc removal for a 12-bit converter. A sample
// that does not close a group of OVERSAMPLE is taken and the block stays idle; the
// sample that closes a group holds the input while one shared 20-bit bit-serial
// divider runs three passes (group average, scale by 255/1564, window mean), each
// ending in a done strobe, with steps for the scale setup, the window memory update,
// the mean setup and the output load between and after them. Results
// sit in an output register, so a new sample is taken while one result waits; the
// next finished result holds the input until the waiting one is taken. Register writes
// take effect immediately and belong in idle periods.
// depends on adc_dcr_pkg, adc_dcr_if, adc_dcr_div, adc_decimate_dc_remove_core_assert.svh
module adc_decimate_dc_remove_core #(
	parameter int OVERSAMPLE   = adc_dcr_pkg::OVERSAMPLE_DEF,
	parameter int WINDOW_DEPTH = adc_dcr_pkg::WINDOW_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	adc_dcr_in_if.sink    samples,
	adc_dcr_out_if.source results,
	adc_dcr_cfg_if.sink   cfg
);

	`include "adc_decimate_dc_remove_core_assert.svh"

	localparam int RAW_W  = adc_dcr_pkg::RAW_W;
	localparam int LVL_W  = adc_dcr_pkg::LVL_W;
	localparam int OFF_W  = adc_dcr_pkg::OFF_W;
	localparam int WLEN_W = adc_dcr_pkg::WLEN_W;
	localparam int PROD_W = adc_dcr_pkg::PROD_W;
	localparam int SUM_W  = $clog2(OVERSAMPLE * adc_dcr_pkg::INV_MAX + 1);
	localparam int PH_W   = $clog2(OVERSAMPLE + 1);
	localparam int PTR_W  = $clog2(WINDOW_DEPTH);
	localparam int FC_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int WS_W   = $clog2(WINDOW_DEPTH * (-adc_dcr_pkg::SAT_MIN) + 1) + 1;
	localparam int WMAG_W = WS_W - 1;
	localparam int D1_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int DIV_W  = (D1_W > WMAG_W) ? D1_W : WMAG_W;
	localparam int WLC_W  = (WLEN_W > FC_W) ? WLEN_W : FC_W;
	localparam int OD_W   = FC_W + 1;
	localparam int X_W    = OFF_W + 1;
	localparam int M_W    = LVL_W + 2;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_AVG    = 3'd1;
	localparam logic [2:0] ST_PREP   = 3'd2;
	localparam logic [2:0] ST_LVL    = 3'd3;
	localparam logic [2:0] ST_UPD    = 3'd4;
	localparam logic [2:0] ST_MSTART = 3'd5;
	localparam logic [2:0] ST_MEAN   = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0]              state_q;
	logic [PH_W-1:0]         phase_q;
	logic [SUM_W-1:0]        sum_q;
	logic [OFF_W-1:0]        off_q;
	logic [WLEN_W-1:0]       wlen_q;
	logic signed [X_W-1:0]   x_q;
	logic                    neg_q;
	logic signed [LVL_W-1:0] level_q;
	logic signed [LVL_W-1:0] rd_q;
	logic signed [WS_W-1:0]  ws_q;
	logic [FC_W-1:0]         fill_q;
	logic [PTR_W-1:0]        wp_q;
	logic                    wneg_q;
	logic                    out_valid_q;
	logic signed [LVL_W-1:0] out_level_q;
	logic signed [LVL_W-1:0] out_filt_q;
	logic signed [LVL_W-1:0] win_mem [WINDOW_DEPTH];

	logic                    accept;
	logic [RAW_W-1:0]        inv;
	logic [SUM_W-1:0]        sum_next;
	logic [PH_W-1:0]         ph_next;
	logic                    grp_end;
	logic [X_W-1:0]          x_abs;
	logic [PROD_W-1:0]       prod;
	logic [WS_W-1:0]         ws_abs;
	logic [WLC_W-1:0]        wl_eff;
	logic                    drop;
	logic [OD_W-1:0]         od;
	logic [OD_W-1:0]         od_fix;
	logic [PTR_W-1:0]        old_idx;
	logic signed [LVL_W-1:0] lvl_sat;
	logic signed [M_W-1:0]   mean;
	logic signed [M_W-1:0]   filt;
	logic signed [LVL_W-1:0] filt_sat;
	logic signed [WS_W-1:0]  ws_sub;
	logic                    out_load;
	logic                    div_wait;

	logic                    div_start;
	logic [DIV_W-1:0]        div_num;
	logic [DIV_W-1:0]        div_den;
	logic [DIV_W-1:0]        div_quo;
	adc_dcr_pkg::div_stat_t  div_stat;

	adc_dcr_div #(.W(DIV_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;

	// group accumulation
	assign inv      = RAW_W'(adc_dcr_pkg::INV_MAX) - samples.raw_sample;
	assign sum_next = (samples.burst_start ? '0 : sum_q) + SUM_W'(inv);
	assign ph_next  = (samples.burst_start ? '0 : phase_q) + 1'b1;
	assign grp_end  = (ph_next == PH_W'(OVERSAMPLE));

	// level scaling operands
	assign x_abs = x_q[X_W-1] ? X_W'(-x_q) : X_W'(x_q);
	assign prod  = {x_abs[OFF_W-1:0], 8'h00} - PROD_W'(x_abs[OFF_W-1:0]);

	assign ws_abs = ws_q[WS_W-1] ? WS_W'(-ws_q) : WS_W'(ws_q);

	// effective window length and oldest counted entry
	assign wl_eff = (wlen_q == '0) ? WLC_W'(1) :
		((WLC_W'(wlen_q) > WLC_W'(WINDOW_DEPTH)) ? WLC_W'(WINDOW_DEPTH) : WLC_W'(wlen_q));
	assign drop    = (WLC_W'(fill_q) >= wl_eff);
	assign od      = OD_W'(wp_q) - OD_W'(fill_q);
	assign od_fix  = od[OD_W-1] ? (od + OD_W'(WINDOW_DEPTH)) : od;
	assign old_idx = od_fix[PTR_W-1:0];
	assign ws_sub  = drop ? WS_W'(rd_q) : WS_W'(0);

	always_comb begin
		if (!neg_q) begin
			lvl_sat = (div_quo > DIV_W'(adc_dcr_pkg::SAT_MAX)) ?
				LVL_W'(adc_dcr_pkg::SAT_MAX) : LVL_W'(div_quo[LVL_W-1:0]);
		end else begin
			lvl_sat = (div_quo > DIV_W'(-adc_dcr_pkg::SAT_MIN)) ?
				LVL_W'(adc_dcr_pkg::SAT_MIN) : LVL_W'(-div_quo[LVL_W-1:0]);
		end
	end

	always_comb begin
		mean = wneg_q ? -M_W'({1'b0, div_quo[LVL_W:0]}) : M_W'({1'b0, div_quo[LVL_W:0]});
		filt = M_W'(level_q) - mean;
		if (filt > M_W'(adc_dcr_pkg::SAT_MAX)) begin
			filt_sat = LVL_W'(adc_dcr_pkg::SAT_MAX);
		end else if (filt < M_W'(adc_dcr_pkg::SAT_MIN)) begin
			filt_sat = LVL_W'(adc_dcr_pkg::SAT_MIN);
		end else begin
			filt_sat = filt[LVL_W-1:0];
		end
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && grp_end) begin
					div_start = 1'b1;
					div_num   = DIV_W'(sum_next);
					div_den   = DIV_W'(OVERSAMPLE);
				end
			end
			ST_PREP: begin
				div_start = 1'b1;
				div_num   = DIV_W'(prod);
				div_den   = DIV_W'(adc_dcr_pkg::SCALE_DIV);
			end
			ST_MSTART: begin
				div_start = 1'b1;
				div_num   = DIV_W'(ws_abs[WMAG_W-1:0]);
				div_den   = DIV_W'(fill_q);
			end
			default: begin
			end
		endcase
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || results.ready);
	assign div_wait = (state_q == ST_AVG) || (state_q == ST_LVL) || (state_q == ST_MEAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			sum_q   <= '0;
			ws_q    <= '0;
			fill_q  <= '0;
			wp_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (samples.burst_start) begin
							ws_q   <= '0;
							fill_q <= '0;
						end
						if (grp_end) begin
							phase_q <= '0;
							sum_q   <= '0;
							state_q <= ST_AVG;
						end else begin
							phase_q <= ph_next;
							sum_q   <= sum_next;
						end
					end
				end
				ST_AVG: begin
					if (div_stat.done) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_LVL;
				end
				ST_LVL: begin
					if (div_stat.done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					ws_q    <= ws_q + WS_W'(level_q) - ws_sub;
					fill_q  <= drop ? fill_q : fill_q + 1'b1;
					wp_q    <= (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
					state_q <= ST_MSTART;
				end
				ST_MSTART: begin
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_AVG && div_stat.done) begin
			x_q <= X_W'({1'b0, div_quo[OFF_W-1:0]}) - X_W'({1'b0, off_q});
		end
		if (state_q == ST_PREP) begin
			neg_q <= x_q[X_W-1];
		end
		if (state_q == ST_LVL && div_stat.done) begin
			level_q <= lvl_sat;
		end
		if (state_q == ST_MSTART) begin
			wneg_q <= ws_q[WS_W-1];
		end
	end

	// window memory
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			win_mem[wp_q] <= level_q;
		end
		rd_q <= win_mem[old_idx];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= OFF_W'(adc_dcr_pkg::OFF_RESET);
			wlen_q <= WLEN_W'(adc_dcr_pkg::WLEN_RESET);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				adc_dcr_pkg::REG_DC_OFFSET: begin
					off_q <= cfg.data[OFF_W-1:0];
				end
				adc_dcr_pkg::REG_WINDOW_LENGTH: begin
					wlen_q <= cfg.data[WLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q <= level_q;
			out_filt_q  <= filt_sat;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.level_sample    = out_level_q;
	assign results.filtered_sample = out_filt_q;

	`ADC_DCR_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
	`ADC_DCR_ASSERT_SAME(a_div_done_state, div_stat.done, div_wait, "divider done outside a wait")
	`ADC_DCR_ASSERT_SAME(a_fill_range, 1'b1, fill_q <= FC_W'(WINDOW_DEPTH), "fill above depth")
	`ADC_DCR_ASSERT_NEXT(a_fill_nonzero, state_q == ST_UPD, fill_q != '0, "empty window after update")

endmodule
